>>> design/nwl_pkg.sv
package nwl_pkg;

    // Widths of the request and result fields.
    localparam int CMD_W      = 2;
    localparam int SLOT_IN_W  = 4;
    localparam int KEY_IN_W   = 10;
    localparam int STATUS_W   = 3;
    localparam int RELCNT_W   = 7;
    localparam int LOCK_W     = 6;

    // Default sizes of the lock table.
    localparam int DEF_KEYS     = 1024;
    localparam int DEF_SLOTS    = 16;
    localparam int DEF_MAX_HELD = 64;

    // Request commands; the spare code also releases everything.
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_READ_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_WRITE_GRANTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UPGRADED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_HELD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABORTED       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RELEASED      = 3'd5;

    // Lock counter codes: the write mark, and the highest reader count.
    localparam logic [LOCK_W-1:0] WRITE_MARK   = 6'd63;
    localparam logic [LOCK_W-1:0] READER_LIMIT = 6'd62;
    localparam logic [LOCK_W-1:0] ONE_READER   = 6'd1;
    localparam logic [LOCK_W-1:0] UNLOCKED     = 6'd0;
    localparam logic [RELCNT_W-1:0] RELCNT_MAX = 7'd127;

endpackage

>>> design/no_wait_rw_lock_manager.sv
// No-wait reader/writer lock manager.
// A request transaction on the s_ channel carries a command (read lock, write
// lock, or release all), a slot and a key. Every request yields exactly one
// result transaction on the m_ channel: a status and the number of locks freed.
// The per-key lock counters live in a KEYS-deep memory; the keys each slot
// holds for reading and for writing live in two SLOTS*MAX_HELD-deep memories.
// Each request is accepted and its key and slot are reduced into range; then:
//   acquire: the slot's lists are searched, with a list move for an upgrade;
//   release: both lists are walked; an abort walks them after its search.
// The result then goes into the output register. The block takes no new
// request until the result of the last one is in the output register.
// After reset the block sweeps the counter memory, one key per cycle, and
// accepts no request until it is done.
// When the receiver stalls, one result waits in the output register while the
// next request is taken and processed; that request's result then waits until
// the register is free.
module no_wait_rw_lock_manager #(
    parameter int KEYS     = nwl_pkg::DEF_KEYS,
    parameter int SLOTS    = nwl_pkg::DEF_SLOTS,
    parameter int MAX_HELD = nwl_pkg::DEF_MAX_HELD
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[1:0], slot[5:2], key[15:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], released_count[9:3], zeros
);
    import nwl_pkg::*;

    localparam int KW    = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW    = $clog2(MAX_HELD + 1);
    localparam int NW    = TW + 1;
    localparam int DEPTH = SLOTS * MAX_HELD;
    localparam int LW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_REDUCE, S_SEARCH, S_DECIDE,
        S_MOVE_RD, S_MOVE_WR, S_RELEASE, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        D_HELD, D_ABORT, D_GRANT_R, D_GRANT_W, D_UPGRADE
    } decision_t;

    state_t              state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [KW-1:0]       key_reg;
    logic [SW-1:0]       slot_reg;
    logic [NW-1:0]       idx_reg;
    logic                rhit_reg;
    logic                whit_reg;
    logic [TW-1:0]       rpos_reg;
    logic                v1_reg;
    logic                op1_reg;
    logic                v2_reg;
    logic                op2_reg;
    logic [KW-1:0]       k2_reg;
    logic [KW-1:0]       clr_reg;
    logic [STATUS_W-1:0] res_st_reg;
    logic [RELCNT_W-1:0] res_cnt_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_st_reg;
    logic [RELCNT_W-1:0] m_cnt_reg;
    logic [TW-1:0]       rt_reg [SLOTS];
    logic [TW-1:0]       wt_reg [SLOTS];

    // Memories and their registered read data.
    logic [LOCK_W-1:0] lock_mem [KEYS];
    logic [KW-1:0]     rd_mem   [DEPTH];
    logic [KW-1:0]     wr_mem   [DEPTH];
    logic [LOCK_W-1:0] lock_q;
    logic [KW-1:0]     rd_q;
    logic [KW-1:0]     wr_q;

    logic [KW-1:0]     lock_ra;
    logic              lock_we;
    logic [KW-1:0]     lock_wa;
    logic [LOCK_W-1:0] lock_wd;
    logic [LW-1:0]     rd_ra;
    logic              rd_we;
    logic [LW-1:0]     rd_wa;
    logic [KW-1:0]     rd_wd;
    logic [LW-1:0]     wr_ra;
    logic              wr_we;
    logic [LW-1:0]     wr_wa;

    logic              red_start;
    logic              red_done;
    logic [KW-1:0]     red_key;
    logic [SW-1:0]     red_slot;

    logic [TW-1:0]     rt;
    logic [TW-1:0]     wt;
    logic [NW-1:0]     held_n;
    logic [NW-1:0]     held_max;
    logic [NW-1:0]     pidx;
    logic [31:0]       base;
    logic [KW-1:0]     walk_key;
    logic              list_full;
    logic              out_load;
    decision_t         dec;

    // Key and slot reduction into range.
    assign red_start = (state_reg == S_IDLE) && s_tvalid;

    nwl_mod_unit #(
        .KEYS  (KEYS),
        .SLOTS (SLOTS)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (red_start),
        .key_in   (s_tdata[15:6]),
        .slot_in  (s_tdata[5:2]),
        .done     (red_done),
        .key_out  (red_key),
        .slot_out (red_slot)
    );

    // Per-slot list lengths and addressing.
    assign rt        = rt_reg[slot_reg];
    assign wt        = wt_reg[slot_reg];
    assign held_n    = NW'(rt) + NW'(wt);
    assign held_max  = (rt > wt) ? NW'(rt) : NW'(wt);
    assign pidx      = idx_reg - 1'b1;
    assign base      = 32'(slot_reg) * 32'(MAX_HELD);
    assign walk_key  = op1_reg ? wr_q : rd_q;
    assign list_full = 32'(held_n) >= 32'(MAX_HELD);

    // The finished result moves into the output register once it is free.
    assign out_load  = (state_reg == S_FIN) && (!m_valid_reg || m_tready);

    // Outcome of an acquire once both lists have been searched.
    always_comb begin
        dec = D_HELD;
        if (cmd_reg == CMD_READ) begin
            if (rhit_reg || whit_reg) begin
                dec = D_HELD;
            end else if (lock_q >= READER_LIMIT || list_full) begin
                dec = D_ABORT;
            end else begin
                dec = D_GRANT_R;
            end
        end else begin
            if (whit_reg) begin
                dec = D_HELD;
            end else if (rhit_reg) begin
                dec = (lock_q != ONE_READER) ? D_ABORT : D_UPGRADE;
            end else if (lock_q != UNLOCKED || list_full) begin
                dec = D_ABORT;
            end else begin
                dec = D_GRANT_W;
            end
        end
    end

    // Memory port control.
    always_comb begin
        lock_ra = (state_reg == S_RELEASE) ? walk_key : key_reg;
        lock_we = 1'b0;
        lock_wa = key_reg;
        lock_wd = WRITE_MARK;
        rd_ra   = LW'(base + 32'(idx_reg));
        rd_we   = 1'b0;
        rd_wa   = LW'(base + 32'(rt));
        rd_wd   = key_reg;
        wr_ra   = LW'(base + 32'(idx_reg - NW'(rt)));
        wr_we   = 1'b0;
        wr_wa   = LW'(base + 32'(wt));
        unique case (state_reg)
            S_CLEAR: begin
                lock_we = 1'b1;
                lock_wa = clr_reg;
                lock_wd = UNLOCKED;
            end
            S_SEARCH: begin
                wr_ra = LW'(base + 32'(idx_reg));
            end
            S_DECIDE: begin
                if (dec == D_GRANT_R) begin
                    lock_we = 1'b1;
                    lock_wd = lock_q + 1'b1;
                    rd_we   = 1'b1;
                end else if (dec == D_GRANT_W || dec == D_UPGRADE) begin
                    lock_we = 1'b1;
                    wr_we   = 1'b1;
                end
            end
            S_MOVE_RD: begin
                rd_ra = LW'(base + 32'(rt) - 32'd1);
            end
            S_MOVE_WR: begin
                rd_we = 1'b1;
                rd_wa = LW'(base + 32'(rpos_reg));
                rd_wd = rd_q;
            end
            S_RELEASE: begin
                if (v2_reg) begin
                    lock_we = 1'b1;
                    lock_wa = k2_reg;
                    lock_wd = op2_reg ? (lock_q + 1'b1) : (lock_q - 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    // Counter memory.
    always_ff @(posedge aclk) begin
        if (lock_we) begin
            lock_mem[lock_wa] <= lock_wd;
        end
        lock_q <= lock_mem[lock_ra];
    end

    // Held-key lists.
    always_ff @(posedge aclk) begin
        if (rd_we) begin
            rd_mem[rd_wa] <= rd_wd;
        end
        rd_q <= rd_mem[rd_ra];
    end

    always_ff @(posedge aclk) begin
        if (wr_we) begin
            wr_mem[wr_wa] <= key_reg;
        end
        wr_q <= wr_mem[wr_ra];
    end

    // Sequencer, list lengths and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                rt_reg[i] <= '0;
                wt_reg[i] <= '0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == KW'(KEYS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= s_tdata[1:0];
                        state_reg <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (red_done) begin
                        key_reg    <= red_key;
                        slot_reg   <= red_slot;
                        idx_reg    <= '0;
                        rhit_reg   <= 1'b0;
                        whit_reg   <= 1'b0;
                        v1_reg     <= 1'b0;
                        v2_reg     <= 1'b0;
                        res_cnt_reg <= '0;
                        if (cmd_reg[1]) begin
                            res_st_reg <= ST_RELEASED;
                            state_reg  <= S_RELEASE;
                        end else begin
                            state_reg  <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // Compare the entries read in the previous cycle.
                    if (idx_reg != '0) begin
                        if (NW'(pidx) < NW'(rt) && rd_q == key_reg) begin
                            rhit_reg <= 1'b1;
                            rpos_reg <= TW'(pidx);
                        end
                        if (NW'(pidx) < NW'(wt) && wr_q == key_reg) begin
                            whit_reg <= 1'b1;
                        end
                    end
                    if (idx_reg == held_max) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DECIDE: begin
                    unique case (dec)
                        D_HELD: begin
                            res_st_reg <= ST_ALREADY_HELD;
                            state_reg  <= S_FIN;
                        end
                        D_GRANT_R: begin
                            rt_reg[slot_reg] <= rt + 1'b1;
                            res_st_reg <= ST_READ_GRANTED;
                            state_reg  <= S_FIN;
                        end
                        D_GRANT_W: begin
                            wt_reg[slot_reg] <= wt + 1'b1;
                            res_st_reg <= ST_WRITE_GRANTED;
                            state_reg  <= S_FIN;
                        end
                        D_UPGRADE: begin
                            wt_reg[slot_reg] <= wt + 1'b1;
                            res_st_reg <= ST_UPGRADED;
                            state_reg  <= S_MOVE_RD;
                        end
                        default: begin
                            res_st_reg <= ST_ABORTED;
                            idx_reg    <= '0;
                            v1_reg     <= 1'b0;
                            v2_reg     <= 1'b0;
                            state_reg  <= S_RELEASE;
                        end
                    endcase
                end
                S_MOVE_RD: begin
                    state_reg <= S_MOVE_WR;
                end
                S_MOVE_WR: begin
                    // The last read entry fills the gap of the upgraded key.
                    rt_reg[slot_reg] <= rt - 1'b1;
                    state_reg        <= S_FIN;
                end
                S_RELEASE: begin
                    // Three-stage walk: list read, counter read, counter write.
                    v1_reg  <= idx_reg < held_n;
                    op1_reg <= idx_reg >= NW'(rt);
                    v2_reg  <= v1_reg;
                    op2_reg <= op1_reg;
                    k2_reg  <= walk_key;
                    if (idx_reg == held_n + 1'b1) begin
                        rt_reg[slot_reg] <= '0;
                        wt_reg[slot_reg] <= '0;
                        res_cnt_reg <= (32'(held_n) > 32'(RELCNT_MAX)) ?
                                       RELCNT_MAX : RELCNT_W'(held_n);
                        state_reg   <= S_FIN;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        m_st_reg    <= res_st_reg;
                        m_cnt_reg   <= res_cnt_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_cnt_reg, m_st_reg};

`ifndef SYNTHESIS
    // A slot never holds more locks than its lists can take.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH || state_reg == S_DECIDE || state_reg == S_RELEASE)
        |-> (32'(rt) + 32'(wt) <= 32'(MAX_HELD)))
        else $error("held list length exceeds its limit");

    // A released read lock finds a reader count on its key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RELEASE && v2_reg && !op2_reg)
        |-> (lock_q != UNLOCKED && lock_q != WRITE_MARK))
        else $error("read lock released on a key without readers");

    // A released write lock finds the write mark on its key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RELEASE && v2_reg && op2_reg) |-> (lock_q == WRITE_MARK))
        else $error("write lock released on a key without the write mark");

    // A granted read never pushes the counter to the write mark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE && dec == D_GRANT_R) |-> (lock_q < READER_LIMIT))
        else $error("read grant beyond the reader limit");
`endif

endmodule

>>> design/nwl_mod_unit.sv
module nwl_mod_unit #(
    parameter int KEYS  = nwl_pkg::DEF_KEYS,
    parameter int SLOTS = nwl_pkg::DEF_SLOTS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [nwl_pkg::KEY_IN_W-1:0]           key_in,
    input  logic [nwl_pkg::SLOT_IN_W-1:0]          slot_in,
    output logic                                   done,
    output logic [((KEYS > 1) ? $clog2(KEYS) : 1)-1:0]   key_out,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_out
);
    import nwl_pkg::*;

    localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Reciprocal scaling by twice the input width keeps the quotient exact
    // for every input value. A range that covers all inputs passes through.
    localparam int KEY_SHIFT  = 2 * KEY_IN_W;
    localparam int SLOT_SHIFT = 2 * SLOT_IN_W;
    localparam int KEY_RECIP  = (KEYS < (1 << KEY_IN_W)) ?
                                ((1 << KEY_SHIFT) + KEYS - 1) / KEYS : 1;
    localparam int SLOT_RECIP = (SLOTS < (1 << SLOT_IN_W)) ?
                                ((1 << SLOT_SHIFT) + SLOTS - 1) / SLOTS : 1;

    logic [KEY_IN_W-1:0]  key_reg;
    logic [SLOT_IN_W-1:0] slot_reg;
    logic [KEY_IN_W-1:0]  key_quo_reg;
    logic [SLOT_IN_W-1:0] slot_quo_reg;
    logic [KEY_IN_W-1:0]  key_rem_reg;
    logic [SLOT_IN_W-1:0] slot_rem_reg;
    logic                 quo_step_reg;
    logic                 rem_step_reg;
    logic                 done_reg;
    logic [31:0]          key_prod;
    logic [31:0]          slot_prod;
    logic [31:0]          key_back;
    logic [31:0]          slot_back;

    // Quotient estimate, then the multiple of the range to take away.
    assign key_prod  = 32'(key_reg) * 32'(KEY_RECIP);
    assign slot_prod = 32'(slot_reg) * 32'(SLOT_RECIP);
    assign key_back  = 32'(key_quo_reg) * 32'(KEYS);
    assign slot_back = 32'(slot_quo_reg) * 32'(SLOTS);

    // Capture, then quotient, then remainder, each registered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quo_step_reg <= 1'b0;
            rem_step_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            quo_step_reg <= start;
            rem_step_reg <= quo_step_reg;
            done_reg     <= rem_step_reg;
            if (start) begin
                key_reg  <= key_in;
                slot_reg <= slot_in;
            end
            if (quo_step_reg) begin
                key_quo_reg  <= KEY_IN_W'(key_prod >> KEY_SHIFT);
                slot_quo_reg <= SLOT_IN_W'(slot_prod >> SLOT_SHIFT);
            end
            if (rem_step_reg) begin
                key_rem_reg  <= KEY_IN_W'(32'(key_reg) - key_back);
                slot_rem_reg <= SLOT_IN_W'(32'(slot_reg) - slot_back);
            end
        end
    end

    assign done     = done_reg;
    assign key_out  = KW'(key_rem_reg);
    assign slot_out = SW'(slot_rem_reg);

endmodule

>>> verif/lock_checker.sv
module lock_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nwl_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RELCNT_W-1:0] released;
    } lock_result_t;

    // Shadow of the lock table.
    logic [LOCK_W-1:0]   key_lock[DEF_KEYS];
    logic [KEY_IN_W-1:0] rd_keys[DEF_SLOTS][DEF_MAX_HELD];
    logic [KEY_IN_W-1:0] wr_keys[DEF_SLOTS][DEF_MAX_HELD];
    int                  rd_total[DEF_SLOTS];
    int                  wr_total[DEF_SLOTS];
    lock_result_t        expected_results[$];

    // Frees every lock a slot holds and returns how many were freed.
    function automatic logic [RELCNT_W-1:0] free_slot(int s);
        int n;
        n = 0;
        for (int i = 0; i < rd_total[s]; i++) begin
            key_lock[rd_keys[s][i]] = key_lock[rd_keys[s][i]] - 1'b1;
            n++;
        end
        for (int i = 0; i < wr_total[s]; i++) begin
            key_lock[wr_keys[s][i]] = key_lock[wr_keys[s][i]] + 1'b1;
            n++;
        end
        rd_total[s] = 0;
        wr_total[s] = 0;
        return (n > 127) ? RELCNT_MAX : RELCNT_W'(n);
    endfunction

    // Applies one request to the shadow table and returns its outcome.
    function automatic lock_result_t apply_request(logic [15:0] req);
        logic [CMD_W-1:0]    cmd;
        int                  s;
        logic [KEY_IN_W-1:0] k;
        int                  rpos;
        int                  wpos;
        lock_result_t        r;
        cmd = req[1:0];
        s = req[5:2];
        k = req[15:6];
        rpos = -1;
        wpos = -1;
        r.released = '0;
        for (int i = 0; i < rd_total[s]; i++) if (rpos < 0 && rd_keys[s][i] == k) rpos = i;
        for (int i = 0; i < wr_total[s]; i++) if (wpos < 0 && wr_keys[s][i] == k) wpos = i;
        if (cmd != CMD_READ && cmd != CMD_WRITE) begin
            r.released = free_slot(s);
            r.status = ST_RELEASED;
        end else if (cmd == CMD_READ) begin
            if (rpos >= 0 || wpos >= 0) begin
                r.status = ST_ALREADY_HELD;
            end else if (key_lock[k] >= READER_LIMIT
                         || rd_total[s] + wr_total[s] >= DEF_MAX_HELD) begin
                r.released = free_slot(s);
                r.status = ST_ABORTED;
            end else begin
                key_lock[k] = key_lock[k] + 1'b1;
                rd_keys[s][rd_total[s]] = k;
                rd_total[s]++;
                r.status = ST_READ_GRANTED;
            end
        end else if (wpos >= 0) begin
            r.status = ST_ALREADY_HELD;
        end else if (rpos >= 0) begin
            if (key_lock[k] != ONE_READER) begin
                r.released = free_slot(s);
                r.status = ST_ABORTED;
            end else begin
                key_lock[k] = WRITE_MARK;
                for (int i = rpos; i < rd_total[s] - 1; i++) rd_keys[s][i] = rd_keys[s][i+1];
                rd_total[s]--;
                wr_keys[s][wr_total[s]] = k;
                wr_total[s]++;
                r.status = ST_UPGRADED;
            end
        end else if (key_lock[k] != UNLOCKED
                     || rd_total[s] + wr_total[s] >= DEF_MAX_HELD) begin
            r.released = free_slot(s);
            r.status = ST_ABORTED;
        end else begin
            key_lock[k] = WRITE_MARK;
            wr_keys[s][wr_total[s]] = k;
            wr_total[s]++;
            r.status = ST_WRITE_GRANTED;
        end
        return r;
    endfunction

    // Predict on each accepted request, compare each accepted result.
    always @(posedge aclk) begin
        lock_result_t want;
        int           errors;
        errors = 0;
        if (!aresetn) begin
            fail_count <= 0;
            pending    <= 0;
            expected_results.delete();
            foreach (key_lock[i]) key_lock[i] = UNLOCKED;
            foreach (rd_total[i]) begin
                rd_total[i] = 0;
                wr_total[i] = 0;
            end
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(apply_request(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[2:0] !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[9:3] !== want.released) begin
                        $error("released_count: expected %0d, actual %0d",
                               want.released, m_tdata[9:3]);
                        errors++;
                    end
                    if (m_tdata[15:10] !== '0) begin
                        $error("padding: expected 0, actual %0d", m_tdata[15:10]);
                        errors++;
                    end
                end
            end
            fail_count <= fail_count + errors;
            pending    <= expected_results.size();
        end
    end
endmodule

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nwl_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          quiet_phase = 1'b0;
    bit          hold_off = 1'b0;
    int          idle_cycles = 0;
    int          stall_left = 0;

    always #5 aclk = ~aclk;

    no_wait_rw_lock_manager uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    lock_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // Sends one request transaction, with a random gap before it at times.
    task automatic send_request(logic [1:0] cmd, logic [3:0] slot, logic [9:0] key);
        int gap;
        gap = (!quiet_phase && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {key, slot, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Receiver: random stall bursts, plus one long hold-off; always ready in the quiet phase.
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (quiet_phase) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("no_wait_rw_lock_manager regression: fail");
            $finish;
        end
    end

    // Random request, mostly on a small hot set of keys to provoke conflicts.
    task automatic random_request();
        logic [1:0] cmd;
        logic [9:0] key;
        int         pick;
        pick = $urandom_range(0, 19);
        cmd = (pick < 8) ? CMD_READ : (pick < 15) ? CMD_WRITE :
              ($urandom_range(0, 1) == 0) ? CMD_RELEASE : CMD_SPARE;
        key = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
        send_request(cmd, 4'($urandom), key);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: grants, repeats, upgrade, conflicts, releases.
        send_request(CMD_READ, 4'd0, 10'd0);
        send_request(CMD_READ, 4'd0, 10'd0);
        send_request(CMD_WRITE, 4'd0, 10'd0);
        send_request(CMD_READ, 4'd0, 10'd0);
        send_request(CMD_WRITE, 4'd0, 10'd0);
        send_request(CMD_WRITE, 4'd15, 10'd1023);
        send_request(CMD_READ, 4'd1, 10'd1023);
        send_request(CMD_READ, 4'd2, 10'd5);
        send_request(CMD_READ, 4'd3, 10'd5);
        send_request(CMD_WRITE, 4'd2, 10'd5);
        send_request(CMD_WRITE, 4'd3, 10'd0);
        send_request(CMD_SPARE, 4'd15, 10'd1023);
        send_request(CMD_RELEASE, 4'd0, 10'd0);
        send_request(CMD_RELEASE, 4'd3, 10'd0);

        // Held list full: slot 4 fills its lists, then one more aborts.
        for (int i = 0; i < DEF_MAX_HELD; i++)
            send_request((i % 2) ? CMD_WRITE : CMD_READ, 4'd4, 10'(100 + i));
        send_request(CMD_READ, 4'd4, 10'd300);
        // Many readers from all 16 slots on a few shared keys.
        for (int i = 0; i < 62; i++) begin
            send_request(CMD_READ, 4'(i % 16), 10'(7 + 64 * (i / 16)));
        end
        for (int i = 0; i < 16; i++) send_request(CMD_RELEASE, 4'(i), 10'd0);
        for (int i = 0; i < 62; i++) send_request(CMD_READ, 4'(i % 16), 10'(i < 16 ? 7 : 8));
        for (int i = 0; i < 16; i++) send_request(CMD_RELEASE, 4'(i), 10'd0);

        // Long receiver hold-off while requests keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (6) random_request();
        join

        // Sender pause until every result is in.
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge aclk);

        for (int i = 0; i < 600; i++) random_request();
        quiet_phase = 1'b1;
        for (int i = 0; i < 200; i++) random_request();
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("no_wait_rw_lock_manager regression: pass");
        end else begin
            $display("no_wait_rw_lock_manager regression: fail");
        end
        $finish;
    end
endmodule
